/* rtl/core/pdf_literal_text_extractor_unit_macros.svh */
// Assertion macros shared by the PDF literal text extractor RTL.
// Depends on nothing; included by the top level only.
`ifndef PDF_LITERAL_TEXT_EXTRACTOR_UNIT_MACROS_SVH
`define PDF_LITERAL_TEXT_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PDF_LTE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PDF_LTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/pdf_lte_pkg.sv */
// Package of the PDF literal text extractor: payload types, character codes.
// Depends on nothing; used by every other file of the block but the macro header.
`default_nettype none

package pdf_lte_pkg;

   localparam int unsigned OUTQ_DEPTH_DEFAULT = 4;

   localparam logic [2:0] HDR_LEN = 3'd5;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_P       = 8'h50;
   localparam logic [7:0] CHAR_D       = 8'h44;
   localparam logic [7:0] CHAR_F       = 8'h46;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_B       = 8'h42;
   localparam logic [7:0] CHAR_T       = 8'h54;
   localparam logic [7:0] CHAR_E       = 8'h45;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_LOW_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOW_R   = 8'h72;
   localparam logic [7:0] CHAR_LOW_T   = 8'h74;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic       has_char;
      logic [7:0] text_byte;
      logic       end_of_text;
      logic       status;
   } rsp_payload_type;

   // Up to two results produced by one accepted request.
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type slot0;
      rsp_payload_type slot1;
   } push_type;

endpackage

`default_nettype wire

/* rtl/core/pdf_lte_if.sv */
// Valid/ready channel interfaces for the request and result streams.
// Depends on pdf_lte_pkg for the payload types.
`default_nettype none

interface pdf_lte_req_if;
   logic                        valid;
   logic                        ready;
   pdf_lte_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pdf_lte_rsp_if;
   logic                        valid;
   logic                        ready;
   pdf_lte_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/core/pdf_lte_scan.sv */
// Byte scanner: header check, BT/ET tracking and string extraction state.
// Depends on pdf_lte_pkg; feeds the output queue with up to two results.
`default_nettype none

module pdf_lte_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  pdf_lte_pkg::req_payload_type req_data,
   output pdf_lte_pkg::push_type        push
);
   import pdf_lte_pkg::*;

   typedef struct packed {
      logic in_blk;
      logic in_str;
      logic skip;
      logic emitted;
      logic last_nl;
   } scan_state_type;

   typedef struct packed {
      scan_state_type st;
      logic           emit;
      logic [7:0]     ch;
   } judge_result_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0: r = CHAR_PERCENT;
         3'd1: r = CHAR_P;
         3'd2: r = CHAR_D;
         3'd3: r = CHAR_F;
         3'd4: r = CHAR_DASH;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Judges one byte position given its neighbors.
   function automatic judge_result_type judge(
      input scan_state_type st_i,
      input logic           hdr_ok,
      input logic           has_prev,
      input logic [7:0]     prev,
      input logic [7:0]     cur,
      input logic [7:0]     nxt,
      input logic           has_after,
      input logic [7:0]     after_b
   );
      judge_result_type r;
      logic             left_ws;
      logic             right_ws;
      logic             raw_bs;
      logic             em_req;
      logic [7:0]       em_byte;
      logic [7:0]       esc;
      r        = '{st: st_i, emit: 1'b0, ch: 8'h00};
      left_ws  = !has_prev || is_ws(prev);
      right_ws = !has_after || is_ws(after_b);
      raw_bs   = has_prev && (prev == CHAR_BSLASH);
      em_req   = 1'b0;
      em_byte  = cur;
      case (nxt)
         CHAR_LOW_N: esc = CHAR_NL;
         CHAR_LOW_R: esc = CHAR_CR;
         CHAR_LOW_T: esc = CHAR_TAB;
         default:    esc = nxt;
      endcase
      if (st_i.skip) begin
         r.st.skip = 1'b0;
      end else if ((nxt == CHAR_T) && left_ws && right_ws &&
                   ((cur == CHAR_B) || (cur == CHAR_E))) begin
         r.st.in_blk = (cur == CHAR_B);
         r.st.skip   = 1'b1;
      end else if (st_i.in_blk) begin
         if ((cur == CHAR_LPAREN) && !raw_bs) begin
            r.st.in_str = 1'b1;
         end else if ((cur == CHAR_RPAREN) && !raw_bs) begin
            r.st.in_str = 1'b0;
            em_req      = st_i.emitted && !st_i.last_nl;
            em_byte     = CHAR_SPACE;
         end else if (st_i.in_str) begin
            em_req = 1'b1;
            if (cur == CHAR_BSLASH) begin
               r.st.skip = 1'b1;
               em_byte   = esc;
            end
         end
      end
      if (em_req && hdr_ok) begin
         r.emit       = 1'b1;
         r.ch         = em_byte;
         r.st.emitted = 1'b1;
         r.st.last_nl = (em_byte == CHAR_NL);
      end
      return r;
   endfunction

   logic [7:0]     h0_ff, h1_ff, h2_ff;
   logic [7:0]     h0_in, h1_in, h2_in;
   scan_state_type state_ff, state_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic           hdr_good_ff, hdr_good_in;

   logic             last;
   logic [7:0]       c;
   logic             hdr_ok;
   logic             a_on, b_on, emit_a, emit_b, status;
   scan_state_type   st1;
   judge_result_type ja, jb;
   rsp_payload_type  res_a, res_b, res_none;

   always_comb begin
      c      = req_data.data_byte;
      last   = req_data.last_byte;
      hdr_ok = hdr_good_ff & ~((cnt_ff < HDR_LEN) & (c != hdr_char(cnt_ff)));

      a_on   = (cnt_ff >= 3'd2);
      ja     = judge(state_ff, hdr_ok, cnt_ff >= 3'd3, h0_ff, h1_ff, h2_ff, 1'b1, c);
      st1    = a_on ? ja.st : state_ff;
      emit_a = a_on & ja.emit;

      b_on   = last & (cnt_ff >= 3'd1);
      jb     = judge(st1, hdr_ok, cnt_ff >= 3'd2, h1_ff, h2_ff, c, 1'b0, 8'h00);
      emit_b = b_on & jb.emit;

      cnt_in = (cnt_ff < HDR_LEN) ? cnt_ff + 3'd1 : cnt_ff;
      status = ~(hdr_ok & (cnt_ff >= HDR_LEN - 3'd1));

      res_a    = '{has_char: 1'b1, text_byte: ja.ch, end_of_text: last & ~emit_b,
                   status: status};
      res_b    = '{has_char: 1'b1, text_byte: jb.ch, end_of_text: last, status: status};
      res_none = '{has_char: 1'b0, text_byte: 8'h00, end_of_text: 1'b1, status: status};

      push.slot1 = res_b;
      if (emit_a) begin
         push.slot0 = res_a;
      end else if (emit_b) begin
         push.slot0 = res_b;
      end else begin
         push.slot0 = res_none;
      end
      if (!accept) begin
         push.count = 2'd0;
      end else if (emit_a & emit_b) begin
         push.count = 2'd2;
      end else if (emit_a | emit_b | last) begin
         push.count = 2'd1;
      end else begin
         push.count = 2'd0;
      end

      state_in    = st1;
      hdr_good_in = hdr_ok;
      h0_in       = h1_ff;
      h1_in       = h2_ff;
      h2_in       = c;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         h0_ff       <= 8'h00;
         h1_ff       <= 8'h00;
         h2_ff       <= 8'h00;
         state_ff    <= '0;
         cnt_ff      <= 3'd0;
         hdr_good_ff <= 1'b1;
      end else if (accept) begin
         h0_ff       <= h0_in;
         h1_ff       <= h1_in;
         h2_ff       <= h2_in;
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         hdr_good_ff <= hdr_good_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pdf_lte_outq.sv */
// Result queue: takes up to two results per cycle, hands out one per cycle while the consumer is ready.
// Depends on pdf_lte_pkg and pdf_lte_rsp_if.
`default_nettype none

module pdf_lte_outq #(
   parameter int unsigned DEPTH = pdf_lte_pkg::OUTQ_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pdf_lte_pkg::push_type push,
   output logic                  space_ok,
   pdf_lte_rsp_if.source         rsp
);
   import pdf_lte_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   rsp_payload_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in, wptr_plus1;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   always_comb begin
      wptr_plus1  = ptr_inc(wptr_ff);
      rsp.valid   = (count_ff != '0);
      rsp.payload = mem_ff[rptr_ff];
      pop         = rsp.valid & rsp.ready;
      space_ok    = (count_ff <= CNT_W'(DEPTH - 2));
      case (push.count)
         2'd1:    wptr_in = wptr_plus1;
         2'd2:    wptr_in = ptr_inc(wptr_plus1);
         default: wptr_in = wptr_ff;
      endcase
      rptr_in  = pop ? ptr_inc(rptr_ff) : rptr_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wptr_plus1] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/pdf_literal_text_extractor_unit.sv */
// PDF literal text extractor, top level: byte scanner plus result queue.
// A result is registered in the queue and offered from there, behind any results already queued.
// Throughput: one request per cycle while the result queue has room for two
// entries; a request that yields two results fills two queue entries.
// Reset (synchronous, active high) clears scanner state and empties the queue.
`default_nettype none

`include "pdf_literal_text_extractor_unit_macros.svh"

module pdf_literal_text_extractor_unit #(
   parameter int unsigned OUTQ_DEPTH = pdf_lte_pkg::OUTQ_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   pdf_lte_req_if.sink   req_chan,
   pdf_lte_rsp_if.source rsp_chan
);
   import pdf_lte_pkg::*;

   // A request is taken whenever the queue can absorb the worst case of two
   // results, so the scanner never has to stall in the middle of a byte.
   logic     space_ok;
   logic     accept;
   push_type push;

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid & req_chan.ready;

   // The scanner judges each byte position once two more bytes have arrived,
   // and on the final byte judges both pending positions in the same cycle.
   pdf_lte_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_chan.payload),
      .push     (push)
   );

   // The queue decouples the scanner from a stalled consumer.
   pdf_lte_outq #(
      .DEPTH (OUTQ_DEPTH)
   ) u_outq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_chan)
   );

   // The final byte of a file always produces at least one result.
   `PDF_LTE_ASSERT_NEXT(a_last_gives_result, clock, reset, accept && req_chan.payload.last_byte, rsp_chan.valid, "final byte produced no result")
   // Characters are only extracted from files with a good header.
   `PDF_LTE_ASSERT_IMPL(a_char_status_ok, clock, reset, rsp_chan.valid && rsp_chan.payload.has_char, !rsp_chan.payload.status, "character result carries bad status")
   // An empty result only closes a file.
   `PDF_LTE_ASSERT_IMPL(a_empty_is_end, clock, reset, rsp_chan.valid && !rsp_chan.payload.has_char, rsp_chan.payload.end_of_text && (rsp_chan.payload.text_byte == 8'h00), "empty result is not an end marker")

endmodule

`default_nettype wire
